@@ sv/tfs_pkg.sv @@
// Shared types and constants for the touch frame to screen block.
`timescale 1ns / 1ps

package tfs_pkg;

  // Status byte fields
  localparam logic [7:0] STATUS_READY_MASK = 8'h80;
  localparam logic [7:0] STATUS_COUNT_MASK = 8'h0f;

  // Configuration register indexes
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_PANEL_WIDTH   = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_PANEL_HEIGHT  = 2'd3;

  // Reset values of the size registers
  localparam logic [11:0] SCREEN_WIDTH_RST  = 12'd320;
  localparam logic [11:0] SCREEN_HEIGHT_RST = 12'd240;
  localparam logic [15:0] PANEL_WIDTH_RST   = 16'd240;
  localparam logic [15:0] PANEL_HEIGHT_RST  = 16'd320;

  // Datapath widths: a magnitude of at most 65536 times a 12-bit size fits in 28 bits
  localparam int unsigned SCR_W   = 12;
  localparam int unsigned PNL_W   = 16;
  localparam int unsigned MAG_W   = 17;
  localparam int unsigned NUM_W   = 28;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned MUL_STEPS = SCR_W;
  localparam int unsigned DIV_STEPS = NUM_W;
  localparam int unsigned CNT_W   = $clog2(DIV_STEPS);

  // One frame read from the controller
  typedef struct packed {
    logic        status_ok;
    logic [7:0]  status_byte;
    logic        point_ok;
    logic [15:0] raw_x;
    logic [15:0] raw_y;
  } in_t;

  // One result
  typedef struct packed {
    logic              frame_taken;
    logic              changed;
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic              touching;
  } out_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

  // Controls from the sequencer to each arithmetic lane
  typedef struct packed {
    logic load;
    logic mul_en;
    logic div_en;
  } lane_ctrl_t;

endpackage

@@ sv/touch_frame_to_screen_core.sv @@
// Top level: touch frame handler that maps the first touch point to screen coordinates.
//
// Usage:
//   in_*  : one frame read per transaction (status byte, first point, read flags).
//   out_* : one result per input transaction: frame_taken, changed, position, touching.
//   cfg_* : write port for the four size registers; write only while the block is idle.
// Operation:
//   A frame that needs scaling runs a bit-serial multiply (one bit of the screen
//   size per cycle) and then a restoring divide (one quotient bit per cycle);
//   x and y run in two lanes side by side. Frames that are not ready, have no
//   point, or pass raw values through skip both and go straight to the done state.
//   One frame is worked on at a time; in_stall is high from acceptance until the
//   result is moved into the output register.
// Reset: synchronous, active low; sizes return to 320x240 screen and 240x320 panel,
//   position clears to zero and the touch flag drops.
// Stall: while out_stall holds a result, the next finished result waits in the
//   sequencer and new frames are not taken; a frame may still be accepted while
//   only the output register is occupied.
`timescale 1ns / 1ps

module touch_frame_to_screen_core import tfs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers
  logic [SCR_W-1:0] screen_width_r;
  logic [SCR_W-1:0] screen_height_r;
  logic [PNL_W-1:0] panel_width_r;
  logic [PNL_W-1:0] panel_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r  <= SCREEN_WIDTH_RST;
      screen_height_r <= SCREEN_HEIGHT_RST;
      panel_width_r   <= PANEL_WIDTH_RST;
      panel_height_r  <= PANEL_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_SCREEN_WIDTH:  screen_width_r  <= cfg_wdata[SCR_W-1:0];
        CFG_SCREEN_HEIGHT: screen_height_r <= cfg_wdata[SCR_W-1:0];
        CFG_PANEL_WIDTH:   panel_width_r   <= cfg_wdata[PNL_W-1:0];
        CFG_PANEL_HEIGHT:  panel_height_r  <= cfg_wdata[PNL_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and tracking state
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             in_accept;
  logic             commit;
  lane_ctrl_t       ctrl;

  logic             frame_r;
  logic             point_r;
  logic             bypass_r;
  logic             neg_y_r;
  logic [15:0]      raw_x_r;
  logic [15:0]      raw_y_r;

  logic signed [POS_W-1:0] last_x_r, last_y_r;
  logic             finger_r;

  out_t             out_data_r;
  logic             out_valid_r;

  // Decode of the incoming frame
  logic             frame_in;
  logic             point_in;
  logic             bypass_in;
  logic [PNL_W+1:0] diff_y;
  logic [MAG_W-1:0] mag_x;
  logic [MAG_W-1:0] mag_y;

  assign frame_in  = in_data.status_ok && ((in_data.status_byte & STATUS_READY_MASK) != '0);
  assign point_in  = ((in_data.status_byte & STATUS_COUNT_MASK) != '0) && in_data.point_ok;
  assign bypass_in = (screen_width_r == '0) || (screen_height_r == '0) ||
                     (panel_width_r == '0) || (panel_height_r == '0);

  // panel_width - 1 - raw_x, signed, as sign and magnitude
  assign diff_y = {2'b00, panel_width_r} - {{(PNL_W+1){1'b0}}, 1'b1} - {2'b00, in_data.raw_x};
  assign mag_x  = {1'b0, in_data.raw_y};
  assign mag_y  = diff_y[PNL_W+1] ? MAG_W'(-diff_y) : diff_y[MAG_W-1:0];

  assign in_accept = in_valid && !in_stall;
  assign commit    = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // Next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_accept) begin
          state_nxt = (frame_in && point_in && !bypass_in) ? ST_MUL : ST_DONE;
        end
      end
      ST_MUL: begin
        if (cnt_r == CNT_W'(MUL_STEPS - 1)) begin
          state_nxt = ST_DIV;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DIV: begin
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_DONE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_stall    = (state_r != ST_IDLE);
    ctrl.load   = in_accept;
    ctrl.mul_en = (state_r == ST_MUL);
    ctrl.div_en = (state_r == ST_DIV);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Frame details held while the lanes run
  always_ff @(posedge clk) begin
    if (in_accept) begin
      frame_r  <= frame_in;
      point_r  <= point_in;
      bypass_r <= bypass_in;
      neg_y_r  <= diff_y[PNL_W+1];
      raw_x_r  <= in_data.raw_x;
      raw_y_r  <= in_data.raw_y;
    end
  end

  // Arithmetic lanes: x = raw_y * sw / ph, |y| = |pw - 1 - raw_x| * sh / pw
  logic [NUM_W-1:0] quo_x, quo_y;

  tfs_lane u_lane_x (
    .clk     (clk),
    .ctrl    (ctrl),
    .mag     (mag_x),
    .mult    (screen_width_r),
    .divisor (panel_height_r),
    .quo     (quo_x)
  );

  tfs_lane u_lane_y (
    .clk     (clk),
    .ctrl    (ctrl),
    .mag     (mag_y),
    .mult    (screen_height_r),
    .divisor (panel_width_r),
    .quo     (quo_y)
  );

  // Saturate to 16-bit signed
  logic [POS_W-1:0] new_x, new_y;
  logic [POS_W-1:0] neg_y_val;

  assign neg_y_val = POS_W'(~quo_y[POS_W-1:0] + 1'b1);

  always_comb begin
    if (bypass_r) begin
      new_x = raw_x_r[15] ? 16'h7fff : raw_x_r;
      new_y = raw_y_r[15] ? 16'h7fff : raw_y_r;
    end else begin
      new_x = (quo_x[NUM_W-1:POS_W-1] != '0) ? 16'h7fff : quo_x[POS_W-1:0];
      if (neg_y_r) begin
        new_y = (quo_y > NUM_W'(32768)) ? 16'h8000 : neg_y_val;
      end else begin
        new_y = (quo_y[NUM_W-1:POS_W-1] != '0) ? 16'h7fff : quo_y[POS_W-1:0];
      end
    end
  end

  // Touch tracking and change detection
  logic             changed;
  logic             finger_nxt;
  logic [POS_W-1:0] last_x_nxt, last_y_nxt;

  always_comb begin
    changed    = 1'b0;
    finger_nxt = finger_r;
    last_x_nxt = last_x_r;
    last_y_nxt = last_y_r;
    if (frame_r) begin
      if (point_r) begin
        changed    = (new_x != last_x_r) || (new_y != last_y_r) || !finger_r;
        last_x_nxt = new_x;
        last_y_nxt = new_y;
        finger_nxt = 1'b1;
      end else if (finger_r) begin
        finger_nxt = 1'b0;
        changed    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_x_r <= '0;
      last_y_r <= '0;
      finger_r <= 1'b0;
    end else if (commit) begin
      last_x_r <= last_x_nxt;
      last_y_r <= last_y_nxt;
      finger_r <= finger_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data_r.frame_taken <= frame_r;
      out_data_r.changed     <= changed;
      out_data_r.screen_x    <= last_x_nxt;
      out_data_r.screen_y    <= last_y_nxt;
      out_data_r.touching    <= finger_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ sv/tfs_lane.sv @@
// Bit-serial multiply then restoring divide lane: quo = mag * mult / divisor.
`timescale 1ns / 1ps

module tfs_lane import tfs_pkg::*; (
  input  logic                 clk,
  input  lane_ctrl_t           ctrl,
  input  logic [MAG_W-1:0]     mag,
  input  logic [SCR_W-1:0]     mult,
  input  logic [PNL_W-1:0]     divisor,
  output logic [NUM_W-1:0]     quo
);

  logic [NUM_W-1:0] acc_r, acc_nxt;
  logic [NUM_W-1:0] mcand_r, mcand_nxt;
  logic [SCR_W-1:0] mult_r, mult_nxt;
  logic [PNL_W-1:0] rem_r, rem_nxt;

  logic [PNL_W:0] trial;
  logic [PNL_W:0] trial_sub;
  logic           fits;

  // One restoring step: shift the next numerator bit into the remainder
  assign trial     = {rem_r, acc_r[NUM_W-1]};
  assign trial_sub = trial - {1'b0, divisor};
  assign fits      = (trial >= {1'b0, divisor});

  // Accumulator doubles as the quotient shift register during the divide
  always_comb begin
    acc_nxt   = acc_r;
    mcand_nxt = mcand_r;
    mult_nxt  = mult_r;
    rem_nxt   = rem_r;
    if (ctrl.load) begin
      acc_nxt   = '0;
      mcand_nxt = {{(NUM_W-MAG_W){1'b0}}, mag};
      mult_nxt  = mult;
      rem_nxt   = '0;
    end else if (ctrl.mul_en) begin
      if (mult_r[0]) begin
        acc_nxt = acc_r + mcand_r;
      end
      mcand_nxt = {mcand_r[NUM_W-2:0], 1'b0};
      mult_nxt  = {1'b0, mult_r[SCR_W-1:1]};
    end else if (ctrl.div_en) begin
      acc_nxt = {acc_r[NUM_W-2:0], fits};
      rem_nxt = fits ? trial_sub[PNL_W-1:0] : trial[PNL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    mcand_r <= mcand_nxt;
    mult_r  <= mult_nxt;
    rem_r   <= rem_nxt;
  end

  assign quo = acc_r;

endmodule

@@ sv/tfs_checker.sv @@
// Port-level checker for the touch frame to screen block, with its bind.
`timescale 1ns / 1ps

module tfs_checker import tfs_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input out_t out_data,
  input logic out_valid,
  input logic out_stall
);

  // A stalled result holds its value
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // One frame at a time: the block is busy right after a transaction
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again before the frame was finished");

  // A change is only ever reported for a handled frame
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.changed |-> out_data.frame_taken)
    else $error("change reported without a taken frame");

  // Reset empties the output register
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind touch_frame_to_screen_core tfs_checker u_tfs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_data  (out_data),
  .out_valid (out_valid),
  .out_stall (out_stall)
);

@@ bench/tb_touch_frame_to_screen_core.sv @@
// Testbench for touch_frame_to_screen_core: randomized frames checked against a built-in predictor.
`timescale 1ns / 1ps

module tb_touch_frame_to_screen_core import tfs_pkg::*;;

  localparam int QUIET_LIMIT = 6000;  // cycles with no transaction before giving up
  localparam int HOLD_CYCLES = 400;   // long receiver hold-off
  localparam int DRAIN_WAIT  = 60;    // settle time after the last result
  localparam int RAND_ITEMS  = 148;   // random frames per configuration phase
  localparam int MAX_PRINTS  = 40;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  touch_frame_to_screen_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor copy of the size registers and the touch state
  logic [11:0]        scr_w = SCREEN_WIDTH_RST;
  logic [11:0]        scr_h = SCREEN_HEIGHT_RST;
  logic [15:0]        pnl_w = PANEL_WIDTH_RST;
  logic [15:0]        pnl_h = PANEL_HEIGHT_RST;
  logic signed [15:0] pos_x = '0;
  logic signed [15:0] pos_y = '0;
  logic               finger = 1'b0;

  in_t  frames_to_send[$];
  out_t screen_results_due[$];

  int   mismatches = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   hold_asked = 0;
  int   hold_taken = 0;
  int   hold_left = 0;
  int   quiet_cycles = 0;
  logic in_took;
  logic [15:0] prev_x = '0;
  logic [15:0] prev_y = '0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // Expected result of one frame; advances the predicted touch state
  function automatic out_t map_frame(in_t f);
    out_t r;
    longint rx, ry, nx, ny, sw, sh, pw, ph;
    logic signed [15:0] sx, sy;
    rx = longint'(f.raw_x);
    ry = longint'(f.raw_y);
    sw = longint'(scr_w);
    sh = longint'(scr_h);
    pw = longint'(pnl_w);
    ph = longint'(pnl_h);
    r.frame_taken = 1'b0;
    r.changed = 1'b0;
    if (f.status_ok && (f.status_byte & STATUS_READY_MASK) != 8'h00) begin
      r.frame_taken = 1'b1;
      if ((f.status_byte & STATUS_COUNT_MASK) != 8'h00 && f.point_ok) begin
        if (sw == 0 || sh == 0 || pw == 0 || ph == 0) begin
          // any zero size: raw values pass through
          nx = rx;
          ny = ry;
        end else begin
          nx = (ry * sw) / ph;
          ny = ((pw - 1 - rx) * sh) / pw;
        end
        sx = clamp16(nx);
        sy = clamp16(ny);
        if (sx != pos_x || sy != pos_y || !finger) r.changed = 1'b1;
        pos_x = sx;
        pos_y = sy;
        finger = 1'b1;
      end else if (finger) begin
        // lift: position kept
        finger = 1'b0;
        r.changed = 1'b1;
      end
    end
    r.screen_x = pos_x;
    r.screen_y = pos_y;
    r.touching = finger;
    return r;
  endfunction

  // Random frame, mostly ready frames with a usable point
  function automatic in_t rand_frame();
    in_t f;
    int pick;
    f.status_ok = ($urandom_range(99) < 92);
    f.status_byte = 8'($urandom_range(255));
    if ($urandom_range(99) < 80) f.status_byte[7] = 1'b1;
    if ($urandom_range(99) < 12) f.status_byte[3:0] = 4'h0;
    f.point_ok = ($urandom_range(99) < 90);
    pick = $urandom_range(99);
    if (pick < 20) begin
      // same point again: no movement
      f.raw_x = prev_x;
      f.raw_y = prev_y;
    end else if (pick < 60) begin
      f.raw_x = 16'($urandom_range(pnl_w));
      f.raw_y = 16'($urandom_range(pnl_h));
    end else begin
      f.raw_x = 16'($urandom_range(16'hffff));
      f.raw_y = 16'($urandom_range(16'hffff));
    end
    prev_x = f.raw_x;
    prev_y = f.raw_y;
    return f;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    if (mismatches < MAX_PRINTS)
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic push_frame(input logic ok, input logic [7:0] sb, input logic pok,
                            input logic [15:0] x, input logic [15:0] y);
    in_t f;
    f.status_ok = ok;
    f.status_byte = sb;
    f.point_ok = pok;
    f.raw_x = x;
    f.raw_y = y;
    frames_to_send.push_back(f);
  endtask

  // One register write; block is idle whenever this runs
  task automatic write_size(input logic [CFG_ADDR_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_SCREEN_WIDTH:  scr_w = val[11:0];
      CFG_SCREEN_HEIGHT: scr_h = val[11:0];
      CFG_PANEL_WIDTH:   pnl_w = val;
      CFG_PANEL_HEIGHT:  pnl_h = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_sizes(input logic [15:0] sw, input logic [15:0] sh,
                           input logic [15:0] pw, input logic [15:0] ph);
    write_size(CFG_SCREEN_WIDTH, sw);
    write_size(CFG_SCREEN_HEIGHT, sh);
    write_size(CFG_PANEL_WIDTH, pw);
    write_size(CFG_PANEL_HEIGHT, ph);
  endtask

  // Wait until every frame is sent and every result is back, then settle
  task automatic wait_drained();
    while (frames_to_send.size() != 0 || in_valid || screen_results_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // Driver: offer the next frame once the current one is taken
  always @(negedge clk) begin
    if (!in_valid || in_took) begin
      if (frames_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= frames_to_send.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_asked != hold_taken) begin
      hold_taken = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor: predict on input transactions, check output transactions, watchdog
  always @(posedge clk) begin
    out_t want;
    out_t got;
    if (!rst_n) begin
      in_took <= 1'b0;
      quiet_cycles = 0;
    end else begin
      in_took <= in_valid && !in_stall;
      if (in_valid && !in_stall) screen_results_due.push_back(map_frame(in_data));
      if (out_valid && !out_stall) begin
        got = out_data;
        if (screen_results_due.size() == 0) begin
          flag_mismatch("result with nothing expected", 64'(got), '0);
        end else begin
          want = screen_results_due.pop_front();
          if (got.frame_taken !== want.frame_taken)
            flag_mismatch("frame_taken", 64'(got.frame_taken), 64'(want.frame_taken));
          if (got.changed !== want.changed)
            flag_mismatch("changed", 64'(got.changed), 64'(want.changed));
          if (got.screen_x !== want.screen_x)
            flag_mismatch("screen_x", 64'(got.screen_x), 64'(want.screen_x));
          if (got.screen_y !== want.screen_y)
            flag_mismatch("screen_y", 64'(got.screen_y), 64'(want.screen_y));
          if (got.touching !== want.touching)
            flag_mismatch("touching", 64'(got.touching), 64'(want.touching));
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Stimulus sequence
  initial begin
    int mode;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed frames under the reset sizes
    push_frame(1'b0, 8'h81, 1'b1, 16'd10, 16'd10);        // status read failed
    push_frame(1'b1, 8'h7f, 1'b1, 16'd10, 16'd10);        // not ready
    push_frame(1'b1, 8'h80, 1'b1, 16'd10, 16'd10);        // no points, not down
    push_frame(1'b1, 8'h81, 1'b1, 16'd0, 16'd0);          // touch begins
    push_frame(1'b1, 8'h81, 1'b1, 16'd0, 16'd0);          // same point
    push_frame(1'b1, 8'hff, 1'b1, 16'hffff, 16'hffff);    // both axes saturate
    push_frame(1'b1, 8'h8f, 1'b1, 16'd239, 16'd319);
    push_frame(1'b1, 8'h81, 1'b0, 16'd5, 16'd5);          // point read failed: lift
    push_frame(1'b1, 8'h81, 1'b0, 16'd5, 16'd5);          // lift again, already up
    push_frame(1'b1, 8'h85, 1'b1, 16'd120, 16'd160);
    push_frame(1'b1, 8'h80, 1'b1, 16'd120, 16'd160);      // zero count: lift
    push_frame(1'b1, 8'h82, 1'b1, 16'd240, 16'd0);        // past panel edge, y negative
    push_frame(1'b1, 8'h81, 1'b1, 16'd241, 16'd1);
    push_frame(1'b0, 8'h00, 1'b0, 16'd0, 16'd0);
    push_frame(1'b0, 8'hff, 1'b1, 16'hffff, 16'hffff);    // ignored while down
    push_frame(1'b1, 8'h90, 1'b1, 16'd5, 16'd5);          // bit 4 only: count zero
    push_frame(1'b1, 8'h91, 1'b1, 16'h5555, 16'haaaa);
    push_frame(1'b1, 8'h91, 1'b1, 16'haaaa, 16'h5555);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_sizes(16'd4095, 16'd4095, 16'd1, 16'd1);
        1: set_sizes(16'd0, 16'($urandom_range(4095)), 16'($urandom_range(65535)),
                     16'($urandom_range(65535)));
        2: set_sizes(16'd1, 16'd1, 16'hffff, 16'hffff);
        3: set_sizes(16'($urandom_range(4095, 1)), 16'($urandom_range(4095, 1)),
                     16'($urandom_range(65535, 1)), 16'($urandom_range(65535, 1)));
        4: set_sizes(16'd320, 16'd240, 16'd240, 16'd320);
        5: set_sizes(16'($urandom_range(4095)), 16'($urandom_range(4095)),
                     16'($urandom_range(65535)), 16'd0);
        6: set_sizes({4'ha, 12'($urandom_range(4095, 1))},
                     {4'h5, 12'($urandom_range(4095, 1))},
                     16'($urandom_range(1000, 1)), 16'($urandom_range(1000, 1)));
        default: set_sizes(16'hffff, 16'hffff, 16'hffff, 16'hffff);
      endcase
      mode = p % 4;
      send_idle_pct = (mode == 1) ? 64 : (mode == 3) ? 14 : 0;
      recv_stall_pct = (mode == 2) ? 64 : (mode == 3) ? 14 : 0;
      for (int i = 0; i < RAND_ITEMS; i++) frames_to_send.push_back(rand_frame());
      // receiver holds off while frames keep coming, so the input backs up
      if (p == 4) hold_asked++;
      wait_drained();
    end

    if (screen_results_due.size() != 0)
      flag_mismatch("results never arrived", 64'(screen_results_due.size()), '0);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
